FILE: rtl/core/dahdsr_pkg.sv
package dahdsr_pkg;

   // note phase codes carried on the request channel
   typedef enum logic [1:0] {
      PHASE_OTHER   = 2'd0,
      PHASE_ACTIVE  = 2'd1,
      PHASE_RELEASE = 2'd2,
      PHASE_ENDED   = 2'd3
   } phase_type;

   // configuration register indexes
   localparam int unsigned CsrIndexBits = 3;
   typedef logic [CsrIndexBits-1:0] csr_index_type;

   localparam csr_index_type REG_START_LEVEL   = 3'd0;
   localparam csr_index_type REG_DELAY_LEN     = 3'd1;
   localparam csr_index_type REG_ATTACK_LEN    = 3'd2;
   localparam csr_index_type REG_PEAK_LEVEL    = 3'd3;
   localparam csr_index_type REG_HOLD_LEN      = 3'd4;
   localparam csr_index_type REG_DECAY_LEN     = 3'd5;
   localparam csr_index_type REG_SUSTAIN_LEVEL = 3'd6;
   localparam csr_index_type REG_RELEASE_LEN   = 3'd7;

endpackage

FILE: rtl/core/dahdsr_if.sv
// request channel
interface dahdsr_req_if #(
   parameter int COUNT_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            note_phase;
   logic [COUNT_BITS-1:0] elapsed_samples;
   logic [COUNT_BITS-1:0] release_sample;

   modport source (output valid, output note_phase, output elapsed_samples,
                   output release_sample, input ready);
   modport sink   (input valid, input note_phase, input elapsed_samples,
                   input release_sample, output ready);
endinterface

// result channel
interface dahdsr_rsp_if #(
   parameter int LEVEL_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] level;
   logic                  note_ended;

   modport source (output valid, output level, output note_ended, input ready);
   modport sink   (input valid, input level, input note_ended, output ready);
endinterface

FILE: rtl/core/dahdsr_front.sv
module dahdsr_front
   import dahdsr_pkg::*;
#(
   parameter int LEVEL_BITS = 16,
   parameter int TIME_BITS  = 24,
   parameter int COUNT_BITS = 32,
   parameter int END_LEVEL  = 0,
   localparam int BW = TIME_BITS + 2,
   localparam int QW = 2 * LEVEL_BITS + 2 * TIME_BITS + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   dahdsr_req_if.sink            req_chan,
   input  logic [LEVEL_BITS-1:0] start_level,
   input  logic [LEVEL_BITS-1:0] peak_level,
   input  logic [LEVEL_BITS-1:0] sustain_level,
   input  logic [TIME_BITS-1:0]  attack_len,
   input  logic [TIME_BITS-1:0]  decay_len,
   input  logic [TIME_BITS-1:0]  release_len,
   input  logic [BW-1:0]         end_delay,
   input  logic [BW-1:0]         end_attack,
   input  logic [BW-1:0]         end_hold,
   input  logic [BW-1:0]         end_decay,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [QW-1:0]         out_data
);

   localparam int CW = (COUNT_BITS > BW) ? COUNT_BITS : BW;
   localparam logic [LEVEL_BITS-1:0] EndLevel = LEVEL_BITS'(END_LEVEL);
   localparam logic [TIME_BITS-1:0]  LenOne   = TIME_BITS'(1);

   logic                  valid_ff;
   logic [QW-1:0]         data_ff;
   logic [QW-1:0]         data_in;
   logic                  take;

   logic [CW-1:0]         t_ext;
   logic [COUNT_BITS-1:0] dt;
   logic [LEVEL_BITS-1:0] from_lvl;
   logic [LEVEL_BITS-1:0] to_lvl;
   logic [LEVEL_BITS-1:0] diff;
   logic                  down;
   logic [TIME_BITS-1:0]  pos;
   logic [TIME_BITS-1:0]  len;
   logic                  ended;

   assign take           = !valid_ff || out_ready;
   assign req_chan.ready = take;
   assign out_valid      = valid_ff;
   assign out_data       = data_ff;

   assign t_ext = CW'(req_chan.elapsed_samples);
   assign dt    = req_chan.elapsed_samples - req_chan.release_sample;

   // classify the item into a segment: endpoints, position and length
   always_comb begin
      from_lvl = '0;
      to_lvl   = '0;
      pos      = '0;
      len      = LenOne;
      ended    = 1'b0;
      unique case (phase_type'(req_chan.note_phase))
         PHASE_ACTIVE: begin
            priority if (t_ext <= CW'(end_delay)) begin
               from_lvl = start_level;
               to_lvl   = start_level;
            end else if (t_ext <= CW'(end_attack)) begin
               from_lvl = start_level;
               to_lvl   = peak_level;
               pos      = TIME_BITS'(t_ext - CW'(end_delay));
               len      = attack_len;
            end else if (t_ext <= CW'(end_hold)) begin
               from_lvl = peak_level;
               to_lvl   = peak_level;
            end else if (t_ext <= CW'(end_decay)) begin
               from_lvl = peak_level;
               to_lvl   = sustain_level;
               pos      = TIME_BITS'(t_ext - CW'(end_hold));
               len      = decay_len;
            end else begin
               from_lvl = sustain_level;
               to_lvl   = sustain_level;
            end
         end
         PHASE_RELEASE: begin
            if ({{TIME_BITS{1'b0}}, dt} <= {{COUNT_BITS{1'b0}}, release_len}) begin
               from_lvl = sustain_level;
               to_lvl   = EndLevel;
               if (release_len != '0) begin
                  pos = TIME_BITS'(dt);
                  len = release_len;
               end
            end else begin
               from_lvl = EndLevel;
               to_lvl   = EndLevel;
               ended    = 1'b1;
            end
         end
         PHASE_OTHER, PHASE_ENDED: begin
            from_lvl = '0;
            to_lvl   = '0;
         end
         default: begin
            from_lvl = '0;
            to_lvl   = '0;
         end
      endcase
   end

   // ramp direction and span
   always_comb begin
      down = to_lvl < from_lvl;
      diff = down ? (from_lvl - to_lvl) : (to_lvl - from_lvl);
   end

   assign data_in = {from_lvl, diff, down, pos, len, ended};

   // front output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_chan.valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/core/dahdsr_queue.sv
module dahdsr_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [0:1];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: rtl/core/dahdsr_back.sv
module dahdsr_back #(
   parameter int LEVEL_BITS = 16,
   parameter int TIME_BITS  = 24,
   localparam int QW = 2 * LEVEL_BITS + 2 * TIME_BITS + 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [QW-1:0] in_data,
   dahdsr_rsp_if.source  rsp_chan
);

   localparam int RW = LEVEL_BITS + TIME_BITS;

   logic                  advance;
   logic [LEVEL_BITS-1:0] in_from;
   logic [LEVEL_BITS-1:0] in_diff;
   logic                  in_down;
   logic [TIME_BITS-1:0]  in_pos;
   logic [TIME_BITS-1:0]  in_len;
   logic                  in_ended;

   logic                  valid_ff [0:LEVEL_BITS];
   logic [LEVEL_BITS-1:0] from_ff  [0:LEVEL_BITS];
   logic                  down_ff  [0:LEVEL_BITS];
   logic                  ended_ff [0:LEVEL_BITS];
   logic [TIME_BITS-1:0]  len_ff   [0:LEVEL_BITS];
   logic [RW-1:0]         rem_ff   [0:LEVEL_BITS];
   logic [LEVEL_BITS-1:0] quot_ff  [0:LEVEL_BITS];

   logic                  out_valid_ff;
   logic [LEVEL_BITS-1:0] out_level_ff;
   logic                  out_ended_ff;
   logic [LEVEL_BITS-1:0] level_in;

   // whole pipeline moves together when the result register is free
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign in_ready = advance;

   assign {in_from, in_diff, in_down, in_pos, in_len, in_ended} = in_data;

   // multiply stage: span times position
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         from_ff[0]  <= in_from;
         down_ff[0]  <= in_down;
         ended_ff[0] <= in_ended;
         len_ff[0]   <= in_len;
         rem_ff[0]   <= RW'(in_diff) * RW'(in_pos);
         quot_ff[0]  <= '0;
      end
   end

   // restoring divider, one quotient bit per stage, msb first
   for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_div
      localparam int Bit = LEVEL_BITS - 1 - k;
      logic [RW-1:0]         shifted_len;
      logic                  fits;
      logic [RW-1:0]         rem_in;
      logic [LEVEL_BITS-1:0] quot_in;

      always_comb begin
         shifted_len = RW'(len_ff[k]) << Bit;
         fits        = rem_ff[k] >= shifted_len;
         rem_in      = fits ? (rem_ff[k] - shifted_len) : rem_ff[k];
         quot_in     = quot_ff[k];
         quot_in[Bit] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            from_ff[k+1]  <= from_ff[k];
            down_ff[k+1]  <= down_ff[k];
            ended_ff[k+1] <= ended_ff[k];
            len_ff[k+1]   <= len_ff[k];
            rem_ff[k+1]   <= rem_in;
            quot_ff[k+1]  <= quot_in;
         end
      end
   end

   // apply the ramp offset in its direction
   assign level_in = down_ff[LEVEL_BITS]
                   ? (from_ff[LEVEL_BITS] - quot_ff[LEVEL_BITS])
                   : (from_ff[LEVEL_BITS] + quot_ff[LEVEL_BITS]);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[LEVEL_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_level_ff <= level_in;
         out_ended_ff <= ended_ff[LEVEL_BITS];
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.level      = out_level_ff;
   assign rsp_chan.note_ended = out_ended_ff;

endmodule

FILE: rtl/core/dahdsr_envelope_level_core.sv
// DAHDSR envelope level generator. Each request carries a note phase, the
// elapsed sample count and the release sample; each yields exactly one result
// with the level and an end flag. The block takes one request per clock while
// the result side does not stall and returns results in order. Each item
// passes a classify register, a two-entry queue, a multiply stage, the ramp
// divider, which resolves one quotient bit per pipeline stage, and a result
// register at the end. Segment end points are recomputed from the registers
// in a chain of registers (delay and attack ends, then hold end, then decay
// end), so an item should be accepted only once that chain has taken up the
// last configuration write. All times are in samples.
module dahdsr_envelope_level_core
   import dahdsr_pkg::*;
#(
   parameter int LEVEL_BITS = 16,
   parameter int TIME_BITS  = 24,
   parameter int COUNT_BITS = 32,
   parameter int END_LEVEL  = 0,
   localparam int DW = (LEVEL_BITS > TIME_BITS) ? LEVEL_BITS : TIME_BITS
) (
   input  logic                clock,
   input  logic                reset,
   dahdsr_req_if.sink          req_chan,
   dahdsr_rsp_if.source        rsp_chan,
   input  logic                csr_write_enable,
   input  csr_index_type       csr_index,
   input  logic [DW-1:0]       csr_write_data
);

   localparam int BW = TIME_BITS + 2;
   localparam int QW = 2 * LEVEL_BITS + 2 * TIME_BITS + 2;

   logic [LEVEL_BITS-1:0] start_level_ff;
   logic [TIME_BITS-1:0]  delay_len_ff;
   logic [TIME_BITS-1:0]  attack_len_ff;
   logic [LEVEL_BITS-1:0] peak_level_ff;
   logic [TIME_BITS-1:0]  hold_len_ff;
   logic [TIME_BITS-1:0]  decay_len_ff;
   logic [LEVEL_BITS-1:0] sustain_level_ff;
   logic [TIME_BITS-1:0]  release_len_ff;

   logic [BW-1:0]         end_delay_ff;
   logic [BW-1:0]         end_attack_ff;
   logic [BW-1:0]         end_hold_ff;
   logic [BW-1:0]         end_decay_ff;
   logic [BW-1:0]         end_attack_in;
   logic [BW-1:0]         end_hold_in;
   logic [BW-1:0]         end_decay_in;

   logic                  fq_valid;
   logic                  fq_ready;
   logic [QW-1:0]         fq_data;
   logic                  qb_valid;
   logic                  qb_ready;
   logic [QW-1:0]         qb_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_level_ff   <= LEVEL_BITS'(0);
         delay_len_ff     <= TIME_BITS'(0);
         attack_len_ff    <= TIME_BITS'(240);
         peak_level_ff    <= LEVEL_BITS'(65535);
         hold_len_ff      <= TIME_BITS'(0);
         decay_len_ff     <= TIME_BITS'(2400);
         sustain_level_ff <= LEVEL_BITS'(32768);
         release_len_ff   <= TIME_BITS'(14400);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_START_LEVEL:   start_level_ff   <= csr_write_data[LEVEL_BITS-1:0];
            REG_DELAY_LEN:     delay_len_ff     <= csr_write_data[TIME_BITS-1:0];
            REG_ATTACK_LEN:    attack_len_ff    <= csr_write_data[TIME_BITS-1:0];
            REG_PEAK_LEVEL:    peak_level_ff    <= csr_write_data[LEVEL_BITS-1:0];
            REG_HOLD_LEN:      hold_len_ff      <= csr_write_data[TIME_BITS-1:0];
            REG_DECAY_LEN:     decay_len_ff     <= csr_write_data[TIME_BITS-1:0];
            REG_SUSTAIN_LEVEL: sustain_level_ff <= csr_write_data[LEVEL_BITS-1:0];
            REG_RELEASE_LEN:   release_len_ff   <= csr_write_data[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // segment end points from the registers
   assign end_attack_in = BW'(delay_len_ff) + BW'(attack_len_ff);
   assign end_hold_in   = end_attack_ff + BW'(hold_len_ff);
   assign end_decay_in  = end_hold_ff + BW'(decay_len_ff);

   always_ff @(posedge clock) begin
      end_delay_ff  <= BW'(delay_len_ff);
      end_attack_ff <= end_attack_in;
      end_hold_ff   <= end_hold_in;
      end_decay_ff  <= end_decay_in;
   end

   dahdsr_front #(
      .LEVEL_BITS (LEVEL_BITS),
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS),
      .END_LEVEL  (END_LEVEL)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .start_level   (start_level_ff),
      .peak_level    (peak_level_ff),
      .sustain_level (sustain_level_ff),
      .attack_len    (attack_len_ff),
      .decay_len     (decay_len_ff),
      .release_len   (release_len_ff),
      .end_delay     (end_delay_ff),
      .end_attack    (end_attack_ff),
      .end_hold      (end_hold_ff),
      .end_decay     (end_decay_ff),
      .out_valid     (fq_valid),
      .out_ready     (fq_ready),
      .out_data      (fq_data)
   );

   dahdsr_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   dahdsr_back #(
      .LEVEL_BITS (LEVEL_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (qb_valid),
      .in_ready (qb_ready),
      .in_data  (qb_data),
      .rsp_chan (rsp_chan)
   );

endmodule
